/* rtl/srrt_pkg.sv */
// Shared types and codes for the source-route range table.
package srrt_pkg;

	localparam logic [2:0] MODE_ROUTE_HI = 3'd0;
	localparam logic [2:0] MODE_ROUTE_DF = 3'd1;
	localparam logic [2:0] MODE_ADD      = 3'd2;
	localparam logic [2:0] MODE_DELETE   = 3'd3;
	localparam logic [2:0] MODE_ATTACH   = 3'd4;
	localparam logic [2:0] MODE_DETACH   = 3'd5;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NONAME   = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	localparam logic [1:0] IFST_ABSENT = 2'd0;
	localparam logic [1:0] IFST_UP     = 2'd2;

	localparam logic [31:0] ADDR_BCAST = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] lookup_src;
		logic [31:0] lookup_dst;
		logic [31:0] src_lo;
		logic [31:0] src_hi;
		logic [31:0] dst_lo;
		logic [31:0] dst_hi;
		logic        exclude_dest;
		logic        high_priority;
		logic [3:0]  iface_id;
		logic [1:0]  iface_state;
		logic        admin_ok;
	} srrt_req_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] out_iface;
		logic [1:0] status;
		logic [4:0] total_entries;
		logic [4:0] active_entries;
	} srrt_rsp_t;

	// Per-rule status bits as kept in the rule memory.
	typedef struct packed {
		logic [3:0] iface;
		logic       att;
		logic       run;
		logic       adm;
		logic       high;
		logic       excl;
		logic       used;
	} rule_attr_t;

	localparam int ATTR_W = $bits(rule_attr_t);
	localparam int BOUNDS_W = 128;

endpackage

/* rtl/srrt_chan_if.sv */
// Valid/ready channel carrying one request or one result.
interface srrt_chan_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/srrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module srrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/source_route_range_table.sv */
// Source-route rule table with a one-entry lookup cache, scanned one slot per cycle.
//
//   channel | dir | payload     | meaning
//   req     | in  | srrt_req_t  | route, add, delete, attach or detach request
//   rsp     | out | srrt_rsp_t  | one result per request
//
// Route ends early for a broadcast destination or when no rule is running, else checks the cached
// slot, then scans on a miss; a named add with room, attach and detach scan once; delete scans, then
// sweeps if a rule matches. The rule memory has a single read port, so each pass reads one slot per
// cycle. After reset a clearing pass empties every slot's rule attributes; no request is taken.
// A result waits in the output register; the next request is taken once it is placed there.
module source_route_range_table #(
	parameter int TABLE_ENTRIES = 16
) (
	input logic        clk,
	input logic        arst_n,
	srrt_chan_if.sink   req,
	srrt_chan_if.source rsp
);
	import srrt_pkg::*;

	localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW  = $clog2(TABLE_ENTRIES + 1);
	localparam int AGW = CW;
	localparam int MW  = ATTR_W + AGW;
	localparam logic [IW-1:0]  LAST    = IW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0]  CNT_MAX = CW'(TABLE_ENTRIES);
	localparam logic [AGW-1:0] AGE_MAX = AGW'(TABLE_ENTRIES);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CHIT  = 3'd2;
	localparam logic [2:0] ST_CCHK  = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_SWEEP = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]     state_q;
	srrt_req_t      req_q;
	logic [IW-1:0]  rd_idx_q, d_idx_q;
	logic           rd_run_q, d_vld_q;
	logic [IW-1:0]  cache_slot_q;
	logic           cache_vld_q;
	logic [CW-1:0]  total_q, active_q;
	logic           found_q;
	logic           res_hit_q;
	logic [3:0]     res_if_q;
	logic [1:0]     res_stat_q;
	logic           rsp_vld_q;
	srrt_rsp_t      rsp_q;

	logic           rb_vld_q;
	logic [IW-1:0]  rb_idx_q;
	logic [AGW-1:0] rb_age_q;
	logic [3:0]     rb_if_q;
	logic           dh_vld_q, dd_vld_q, dh_run_q, dd_run_q;
	logic [IW-1:0]  dh_idx_q, dd_idx_q, del_idx_q;
	logic [AGW-1:0] dh_age_q, dd_age_q, del_age_q;

	logic [IW-1:0]         raddr, waddr;
	logic                  m_we, b_we;
	logic [MW-1:0]         m_wdata, m_rd;
	logic [BOUNDS_W-1:0]   b_wdata, b_rd;
	rule_attr_t            attr, new_attr, wattr;
	logic [AGW-1:0]        age;
	logic [31:0]           s_lo, s_hi, d_lo, d_hi;
	logic                  src_in, dst_in, rmatch, rvalid, route_ok, key_ok;
	logic                  take_r, take_dh, take_dd, last;
	logic                  add_slot, att_hit, det_hit;
	logic                  accept;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_vld_q;
	assign rsp.data = rsp_q;

	assign raddr = (state_q == ST_CHIT) ? cache_slot_q : rd_idx_q;
	assign waddr = (state_q == ST_CLR) ? rd_idx_q : d_idx_q;
	assign b_wdata = {req_q.dst_hi, req_q.dst_lo, req_q.src_hi, req_q.src_lo};

	srrt_ram #(.WIDTH(BOUNDS_W), .DEPTH(TABLE_ENTRIES)) u_bounds (
		.clk(clk), .we(b_we), .waddr(waddr), .wdata(b_wdata), .raddr(raddr), .rdata(b_rd)
	);

	srrt_ram #(.WIDTH(MW), .DEPTH(TABLE_ENTRIES)) u_meta (
		.clk(clk), .we(m_we), .waddr(waddr), .wdata(m_wdata), .raddr(raddr), .rdata(m_rd)
	);

	// Shared compare unit: checks the slot just read against the held request.
	always_comb begin
		attr = rule_attr_t'(m_rd[ATTR_W-1:0]);
		age = m_rd[MW-1:ATTR_W];
		s_lo = b_rd[31:0];
		s_hi = b_rd[63:32];
		d_lo = b_rd[95:64];
		d_hi = b_rd[127:96];
		src_in = (req_q.lookup_src >= s_lo) && (req_q.lookup_src <= s_hi);
		dst_in = (req_q.lookup_dst >= d_lo) && (req_q.lookup_dst <= d_hi);
		rmatch = src_in && (attr.excl ? !dst_in : dst_in);
		rvalid = attr.used && attr.adm && attr.run;
		route_ok = rvalid && rmatch && (attr.high == (req_q.mode == MODE_ROUTE_HI));
		key_ok = attr.used && (b_rd == b_wdata);
		last = d_vld_q && (d_idx_q == LAST);
		take_r = d_vld_q && route_ok && (!rb_vld_q || age < rb_age_q);
		take_dh = d_vld_q && key_ok && attr.high && (!dh_vld_q || age < dh_age_q);
		take_dd = d_vld_q && key_ok && !attr.high && (!dd_vld_q || age < dd_age_q);
	end

	always_comb begin
		new_attr.iface = req_q.iface_id;
		new_attr.att = (req_q.iface_state != IFST_ABSENT);
		new_attr.run = (req_q.iface_state == IFST_UP);
		new_attr.adm = req_q.admin_ok;
		new_attr.high = req_q.high_priority;
		new_attr.excl = req_q.exclude_dest;
		new_attr.used = 1'b1;
		wattr = attr;
		m_we = 1'b0;
		b_we = 1'b0;
		m_wdata = m_rd;
		add_slot = 1'b0;
		att_hit = 1'b0;
		det_hit = 1'b0;
		case (state_q)
			ST_CLR: begin
				m_we = 1'b1;
				m_wdata = '0;
			end
			ST_SCAN: begin
				if (d_vld_q) begin
					case (req_q.mode)
						MODE_ADD: begin
							if (!attr.used && !found_q) begin
								m_we = 1'b1;
								b_we = 1'b1;
								add_slot = 1'b1;
								m_wdata = {AGW'(0), new_attr};
							end else if (attr.used && age < AGE_MAX) begin
								m_we = 1'b1;
								m_wdata = {age + AGW'(1), attr};
							end
						end
						MODE_ATTACH: begin
							if (attr.used && !attr.att && attr.iface == req_q.iface_id) begin
								wattr.att = 1'b1;
								wattr.run = 1'b1;
								m_we = 1'b1;
								att_hit = 1'b1;
								m_wdata = {age, wattr};
							end
						end
						MODE_DETACH: begin
							if (attr.used && attr.att && attr.iface == req_q.iface_id) begin
								wattr.att = 1'b0;
								wattr.run = 1'b0;
								m_we = 1'b1;
								det_hit = 1'b1;
								m_wdata = {age, wattr};
							end
						end
						default: ;
					endcase
				end
			end
			ST_SWEEP: begin
				if (d_vld_q) begin
					if (d_idx_q == del_idx_q) begin
						m_we = 1'b1;
						m_wdata = '0;
					end else if (attr.used && age > del_age_q) begin
						m_we = 1'b1;
						m_wdata = {age - AGW'(1), attr};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			rd_idx_q <= '0;
			rd_run_q <= 1'b0;
			d_vld_q <= 1'b0;
			d_idx_q <= '0;
			cache_slot_q <= '0;
			cache_vld_q <= 1'b0;
			total_q <= '0;
			active_q <= '0;
			found_q <= 1'b0;
			rsp_vld_q <= 1'b0;
			rb_vld_q <= 1'b0;
			dh_vld_q <= 1'b0;
			dd_vld_q <= 1'b0;
		end else begin
			d_vld_q <= rd_run_q;
			d_idx_q <= rd_idx_q;
			if (rd_run_q) begin
				rd_idx_q <= rd_idx_q + IW'(1);
				if (rd_idx_q == LAST) begin
					rd_run_q <= 1'b0;
				end
			end
			if (rsp_vld_q && rsp.ready && state_q != ST_FIN) begin
				rsp_vld_q <= 1'b0;
			end

			// Per-slot side effects of the scan.
			if (take_r) begin
				rb_vld_q <= 1'b1;
				rb_idx_q <= d_idx_q;
				rb_age_q <= age;
				rb_if_q <= attr.iface;
			end
			if (take_dh) begin
				dh_vld_q <= 1'b1;
				dh_idx_q <= d_idx_q;
				dh_age_q <= age;
				dh_run_q <= attr.run;
			end
			if (take_dd) begin
				dd_vld_q <= 1'b1;
				dd_idx_q <= d_idx_q;
				dd_age_q <= age;
				dd_run_q <= attr.run;
			end
			if (add_slot) begin
				found_q <= 1'b1;
				if (cache_vld_q && cache_slot_q == d_idx_q) begin
					cache_vld_q <= 1'b0;
				end
			end
			if (att_hit && active_q < CNT_MAX) begin
				active_q <= active_q + CW'(1);
			end
			if (det_hit) begin
				if (active_q != '0) begin
					active_q <= active_q - CW'(1);
				end
				if (cache_vld_q && cache_slot_q == d_idx_q) begin
					cache_vld_q <= 1'b0;
				end
			end

			case (state_q)
				ST_CLR: begin
					rd_idx_q <= rd_idx_q + IW'(1);
					if (rd_idx_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						req_q <= req.data;
						res_hit_q <= 1'b0;
						res_if_q <= '0;
						res_stat_q <= STAT_OK;
						rb_vld_q <= 1'b0;
						dh_vld_q <= 1'b0;
						dd_vld_q <= 1'b0;
						found_q <= 1'b0;
						rd_idx_q <= '0;
						state_q <= ST_FIN;
						case (req.data.mode)
							MODE_ROUTE_HI, MODE_ROUTE_DF: begin
								if (req.data.lookup_dst != ADDR_BCAST && active_q != '0) begin
									if (cache_vld_q) begin
										state_q <= ST_CHIT;
									end else begin
										rd_run_q <= 1'b1;
										state_q <= ST_SCAN;
									end
								end
							end
							MODE_ADD: begin
								if (req.data.iface_id == '0) begin
									res_stat_q <= STAT_NONAME;
								end else if (total_q >= CNT_MAX) begin
									res_stat_q <= STAT_FULL;
								end else begin
									total_q <= total_q + CW'(1);
									if (req.data.iface_state == IFST_UP && active_q < CNT_MAX) begin
										active_q <= active_q + CW'(1);
									end
									rd_run_q <= 1'b1;
									state_q <= ST_SCAN;
								end
							end
							MODE_DELETE, MODE_ATTACH, MODE_DETACH: begin
								rd_run_q <= 1'b1;
								state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_CHIT: begin
					state_q <= ST_CCHK;
				end
				ST_CCHK: begin
					// The cached rule answers for either class.
					if (rvalid && rmatch) begin
						res_hit_q <= 1'b1;
						res_if_q <= attr.iface;
						state_q <= ST_FIN;
					end else begin
						rd_idx_q <= '0;
						rd_run_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last) begin
						state_q <= ST_FIN;
						case (req_q.mode)
							MODE_ROUTE_HI, MODE_ROUTE_DF: begin
								if (take_r || rb_vld_q) begin
									res_hit_q <= 1'b1;
									res_if_q <= take_r ? attr.iface : rb_if_q;
									cache_slot_q <= take_r ? d_idx_q : rb_idx_q;
									cache_vld_q <= 1'b1;
								end
							end
							MODE_DELETE: begin
								if (take_dh || dh_vld_q || take_dd || dd_vld_q) begin
									if (take_dh || dh_vld_q) begin
										del_idx_q <= take_dh ? d_idx_q : dh_idx_q;
										del_age_q <= take_dh ? age : dh_age_q;
										if ((take_dh ? attr.run : dh_run_q) && active_q != '0) begin
											active_q <= active_q - CW'(1);
										end
										if (cache_vld_q && cache_slot_q == (take_dh ? d_idx_q : dh_idx_q)) begin
											cache_vld_q <= 1'b0;
										end
									end else begin
										del_idx_q <= take_dd ? d_idx_q : dd_idx_q;
										del_age_q <= take_dd ? age : dd_age_q;
										if ((take_dd ? attr.run : dd_run_q) && active_q != '0) begin
											active_q <= active_q - CW'(1);
										end
										if (cache_vld_q && cache_slot_q == (take_dd ? d_idx_q : dd_idx_q)) begin
											cache_vld_q <= 1'b0;
										end
									end
									if (total_q != '0) begin
										total_q <= total_q - CW'(1);
									end
									rd_idx_q <= '0;
									rd_run_q <= 1'b1;
									state_q <= ST_SWEEP;
								end else begin
									res_stat_q <= STAT_NOTFOUND;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SWEEP: begin
					if (last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!rsp_vld_q || rsp.ready)) begin
			rsp_q.hit <= res_hit_q;
			rsp_q.out_iface <= res_if_q;
			rsp_q.status <= res_stat_q;
			rsp_q.total_entries <= 5'(total_q);
			rsp_q.active_entries <= 5'(active_q);
		end
	end

	a_active_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= total_q)
		else $error("running rule count exceeds stored rule count");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_MAX)
		else $error("stored rule count above table size");

	a_hit_named: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_q.hit |-> rsp_q.out_iface != '0 && rsp_q.status == STAT_OK)
		else $error("route hit without interface or with error status");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SWEEP) |-> !req.ready)
		else $error("request taken during a table scan");
endmodule

/* bench/tb_source_route_range_table.sv */
// Self-checking testbench for the source-route range table: directed table plus random traffic.
`timescale 1ns / 1ps

module tb_source_route_range_table;
	import srrt_pkg::*;

	localparam int N = 16;
	localparam int N_RANDOM = 1520;
	localparam int QUIET_FROM = 1350;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;

	srrt_chan_if #(.data_t(srrt_req_t)) req_ch ();
	srrt_chan_if #(.data_t(srrt_rsp_t)) rsp_ch ();

	source_route_range_table #(.TABLE_ENTRIES(N)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Shadow copy of the rule table.
	logic [31:0] sh_src_lo [N];
	logic [31:0] sh_src_hi [N];
	logic [31:0] sh_dst_lo [N];
	logic [31:0] sh_dst_hi [N];
	rule_attr_t  sh_attr [N];
	int          sh_age [N];
	int          sh_cache_slot;
	bit          sh_cache_ok;
	int          sh_total;
	int          sh_active;

	srrt_rsp_t expected_rsp_q [$];

	int mismatches;
	int unexpected;
	int idle_cnt;
	int n_sent;
	int n_hits;
	int n_full;
	int n_notfound;
	bit quiet;
	bit hold_rsp;

	// Pool of rule ranges, so deletes and lookups find stored rules.
	logic [31:0] pool_src_lo [8];
	logic [31:0] pool_src_hi [8];
	logic [31:0] pool_dst_lo [8];
	logic [31:0] pool_dst_hi [8];

	function automatic bit rule_live(int s);
		return sh_attr[s].used && sh_attr[s].adm && sh_attr[s].run;
	endfunction

	function automatic bit rule_hit(int s, logic [31:0] a, logic [31:0] b);
		bit in_dst;
		if (a < sh_src_lo[s] || a > sh_src_hi[s])
			return 1'b0;
		in_dst = (b >= sh_dst_lo[s]) && (b <= sh_dst_hi[s]);
		return sh_attr[s].excl ? !in_dst : in_dst;
	endfunction

	function automatic int newest_rule(bit hi_class, bit for_route, srrt_req_t r);
		int best;
		int best_age;
		bit ok;
		best = N;
		best_age = 0;
		for (int s = 0; s < N; s++) begin
			if (!sh_attr[s].used || sh_attr[s].high != hi_class)
				continue;
			if (for_route)
				ok = rule_live(s) && rule_hit(s, r.lookup_src, r.lookup_dst);
			else
				ok = sh_src_lo[s] == r.src_lo && sh_src_hi[s] == r.src_hi &&
					sh_dst_lo[s] == r.dst_lo && sh_dst_hi[s] == r.dst_hi;
			if (ok && (best == N || sh_age[s] < best_age)) begin
				best = s;
				best_age = sh_age[s];
			end
		end
		return best;
	endfunction

	function automatic void drop_cache(int s);
		if (sh_cache_ok && sh_cache_slot == s)
			sh_cache_ok = 1'b0;
	endfunction

	// Applies one request to the shadow table and returns the result it should produce.
	function automatic srrt_rsp_t apply_request(srrt_req_t r);
		srrt_rsp_t o;
		int s;
		o = '0;
		case (r.mode)
			MODE_ROUTE_HI, MODE_ROUTE_DF: begin
				if (r.lookup_dst != ADDR_BCAST && sh_active != 0) begin
					if (sh_cache_ok && rule_live(sh_cache_slot) &&
						rule_hit(sh_cache_slot, r.lookup_src, r.lookup_dst)) begin
						o.hit = 1'b1;
						o.out_iface = sh_attr[sh_cache_slot].iface;
					end else begin
						s = newest_rule(r.mode == MODE_ROUTE_HI, 1'b1, r);
						if (s < N) begin
							o.hit = 1'b1;
							o.out_iface = sh_attr[s].iface;
							sh_cache_slot = s;
							sh_cache_ok = 1'b1;
						end
					end
				end
			end
			MODE_ADD: begin
				if (r.iface_id == 0) begin
					o.status = STAT_NONAME;
				end else begin
					for (s = 0; s < N; s++)
						if (!sh_attr[s].used)
							break;
					if (s >= N) begin
						o.status = STAT_FULL;
					end else begin
						for (int t = 0; t < N; t++)
							if (sh_attr[t].used && sh_age[t] < N)
								sh_age[t]++;
						sh_attr[s] = '0;
						sh_attr[s].used = 1'b1;
						sh_attr[s].excl = r.exclude_dest;
						sh_attr[s].high = r.high_priority;
						sh_attr[s].adm = r.admin_ok;
						sh_attr[s].att = r.iface_state != IFST_ABSENT;
						sh_attr[s].iface = r.iface_id;
						if (r.iface_state == IFST_UP) begin
							sh_attr[s].run = 1'b1;
							if (sh_active < N)
								sh_active++;
						end
						sh_src_lo[s] = r.src_lo;
						sh_src_hi[s] = r.src_hi;
						sh_dst_lo[s] = r.dst_lo;
						sh_dst_hi[s] = r.dst_hi;
						sh_age[s] = 0;
						if (sh_total < N)
							sh_total++;
						drop_cache(s);
					end
				end
			end
			MODE_DELETE: begin
				s = newest_rule(1'b1, 1'b0, r);
				if (s >= N)
					s = newest_rule(1'b0, 1'b0, r);
				if (s >= N) begin
					o.status = STAT_NOTFOUND;
				end else begin
					if (sh_attr[s].run && sh_active > 0)
						sh_active--;
					drop_cache(s);
					if (sh_total > 0)
						sh_total--;
					for (int t = 0; t < N; t++)
						if (sh_attr[t].used && sh_age[t] > sh_age[s])
							sh_age[t]--;
					sh_attr[s] = '0;
					sh_age[s] = 0;
				end
			end
			MODE_ATTACH: begin
				for (s = 0; s < N; s++)
					if (sh_attr[s].used && !sh_attr[s].att && sh_attr[s].iface == r.iface_id) begin
						sh_attr[s].att = 1'b1;
						sh_attr[s].run = 1'b1;
						if (sh_active < N)
							sh_active++;
					end
			end
			MODE_DETACH: begin
				for (s = 0; s < N; s++)
					if (sh_attr[s].used && sh_attr[s].att && sh_attr[s].iface == r.iface_id) begin
						sh_attr[s].att = 1'b0;
						sh_attr[s].run = 1'b0;
						drop_cache(s);
						if (sh_active > 0)
							sh_active--;
					end
			end
			default: ;
		endcase
		o.total_entries = 5'(sh_total);
		o.active_entries = 5'(sh_active);
		return o;
	endfunction

	function automatic srrt_req_t blank_req(logic [2:0] m);
		srrt_req_t r;
		r = '0;
		r.mode = m;
		return r;
	endfunction

	function automatic srrt_req_t add_req(logic [31:0] sl, logic [31:0] sh, logic [31:0] dl,
		logic [31:0] dh, bit ex, bit hp, logic [3:0] ifid, logic [1:0] ifst, bit adm);
		srrt_req_t r;
		r = blank_req(MODE_ADD);
		r.src_lo = sl;
		r.src_hi = sh;
		r.dst_lo = dl;
		r.dst_hi = dh;
		r.exclude_dest = ex;
		r.high_priority = hp;
		r.iface_id = ifid;
		r.iface_state = ifst;
		r.admin_ok = adm;
		return r;
	endfunction

	function automatic srrt_req_t route_req(logic [2:0] m, logic [31:0] a, logic [31:0] b);
		srrt_req_t r;
		r = blank_req(m);
		r.lookup_src = a;
		r.lookup_dst = b;
		return r;
	endfunction

	function automatic srrt_req_t iface_req(logic [2:0] m, logic [3:0] ifid);
		srrt_req_t r;
		r = blank_req(m);
		r.iface_id = ifid;
		return r;
	endfunction

	function automatic logic [31:0] pick_between(logic [31:0] lo, logic [31:0] hi);
		logic [32:0] span;
		if (lo > hi)
			return $urandom();
		span = {1'b0, hi} - {1'b0, lo} + 33'd1;
		return lo + 32'({$urandom(), $urandom()} % span);
	endfunction

	function automatic srrt_req_t random_request(bit add_heavy);
		srrt_req_t r;
		logic [7*32-1:0] raw;
		int p;
		int k;
		int roll;
		raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom()};
		r = raw[$bits(srrt_req_t)-1:0];
		k = $urandom_range(0, 7);
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return r;                   // noise: every field random, modes six and seven too
		r.mode = r.mode % 6;
		p = $urandom_range(0, 99);
		if (add_heavy)
			r.mode = (p < 45) ? MODE_ADD : (p < 80) ? MODE_ROUTE_HI : (p < 90) ? MODE_ROUTE_DF :
				(p < 95) ? MODE_ATTACH : MODE_DELETE;
		else
			r.mode = (p < 25) ? MODE_ROUTE_HI : (p < 50) ? MODE_ROUTE_DF : (p < 66) ? MODE_ADD :
				(p < 84) ? MODE_DELETE : (p < 92) ? MODE_ATTACH : MODE_DETACH;
		if ($urandom_range(0, 9) < 8) begin
			r.src_lo = pool_src_lo[k];
			r.src_hi = pool_src_hi[k];
			r.dst_lo = pool_dst_lo[k];
			r.dst_hi = pool_dst_hi[k];
		end
		if ($urandom_range(0, 9) < 9)
			r.iface_id = 4'($urandom_range(1, 4));
		if (r.iface_state == 2'd3)
			r.iface_state = 2'($urandom_range(0, 2));
		if ($urandom_range(0, 9) < 7) begin
			r.iface_state = IFST_UP;
			r.admin_ok = 1'b1;
		end
		if ($urandom_range(0, 9) < 8) begin
			r.lookup_src = pick_between(pool_src_lo[k], pool_src_hi[k]);
			r.lookup_dst = ($urandom_range(0, 2) != 0) ?
				pick_between(pool_dst_lo[k], pool_dst_hi[k]) : $urandom();
		end
		if ($urandom_range(0, 19) == 0)
			r.lookup_dst = ADDR_BCAST;
		return r;
	endfunction

	task automatic send_request(srrt_req_t r, bit use_typed, srrt_rsp_t typed);
		srrt_rsp_t e;
		int gap;
		if (!quiet && $urandom_range(0, 9) < 2) begin
			gap = $urandom_range(1, 7);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		e = apply_request(r);
		if (use_typed)
			e = typed;
		expected_rsp_q.push_back(e);
		n_sent++;
	endtask

	// Result checker and receiver stall control.
	initial begin
		int stall;
		int hold;
		srrt_rsp_t e;
		srrt_rsp_t a;
		stall = 0;
		hold = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				a = rsp_ch.data;
				if (expected_rsp_q.size() == 0) begin
					unexpected++;
					if (mismatches + unexpected <= 10)
						$display("result with no request pending: %p", a);
				end else begin
					e = expected_rsp_q.pop_front();
					if (a.hit !== e.hit || a.out_iface !== e.out_iface || a.status !== e.status ||
						a.total_entries !== e.total_entries ||
						a.active_entries !== e.active_entries) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", e, a);
					end
					if (a.hit)
						n_hits++;
					if (a.status == STAT_FULL)
						n_full++;
					if (a.status == STAT_NOTFOUND)
						n_notfound++;
				end
			end
			if (hold_rsp && hold == 0) begin
				hold = HOLD_CYCLES;
				hold_rsp = 1'b0;
			end
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) < 2) begin
				stall = $urandom_range(0, 6);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a request or result.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_source_route_range_table: done, errors");
			$finish;
		end
	end

	typedef struct {
		srrt_req_t r;
		bit        typed;
		srrt_rsp_t e;
	} stim_row_t;

	function automatic srrt_rsp_t rsp_of(bit h, logic [3:0] oif, logic [1:0] st, int tot, int act);
		srrt_rsp_t o;
		o.hit = h;
		o.out_iface = oif;
		o.status = st;
		o.total_entries = 5'(tot);
		o.active_entries = 5'(act);
		return o;
	endfunction

	initial begin
		stim_row_t rows [$];
		srrt_rsp_t none;
		int waited;
		none = '0;
		mismatches = 0;
		unexpected = 0;
		idle_cnt = 0;
		n_sent = 0;
		n_hits = 0;
		n_full = 0;
		n_notfound = 0;
		quiet = 1'b0;
		hold_rsp = 1'b0;
		sh_cache_slot = 0;
		sh_cache_ok = 1'b0;
		sh_total = 0;
		sh_active = 0;
		for (int s = 0; s < N; s++) begin
			sh_attr[s] = '0;
			sh_age[s] = 0;
		end
		for (int k = 0; k < 8; k++) begin
			pool_src_lo[k] = $urandom();
			pool_src_hi[k] = pool_src_lo[k] + $urandom_range(0, 32'h00FF_FFFF);
			pool_dst_lo[k] = $urandom();
			pool_dst_hi[k] = pool_dst_lo[k] + $urandom_range(0, 32'h0FFF_FFFF);
		end
		pool_src_lo[0] = '0;
		pool_src_hi[0] = '1;
		pool_dst_lo[0] = '0;
		pool_dst_hi[0] = '1;
		pool_src_lo[1] = 32'hFFFF_FFF0;     // inverted range never matches
		pool_src_hi[1] = 32'h0000_0010;

		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		rows.push_back('{route_req(MODE_ROUTE_HI, 32'd5, 32'd5), 1, rsp_of(0, 0, STAT_OK, 0, 0)});
		rows.push_back('{add_req(0, '1, 0, 10, 0, 1, 4'd0, IFST_UP, 1), 1,
			rsp_of(0, 0, STAT_NONAME, 0, 0)});
		rows.push_back('{add_req(0, '1, 0, 10, 0, 1, 4'd3, IFST_UP, 1), 1,
			rsp_of(0, 0, STAT_OK, 1, 1)});
		rows.push_back('{route_req(MODE_ROUTE_HI, 32'd5, 32'd5), 1, rsp_of(1, 3, STAT_OK, 1, 1)});
		rows.push_back('{route_req(MODE_ROUTE_HI, 32'd5, ADDR_BCAST), 1,
			rsp_of(0, 0, STAT_OK, 1, 1)});
		// The cached high-class rule also answers a default-class lookup.
		rows.push_back('{route_req(MODE_ROUTE_DF, '1, 32'd10), 1, rsp_of(1, 3, STAT_OK, 1, 1)});
		rows.push_back('{add_req(32'd1, 32'd1, 0, 10, 1, 0, 4'd5, IFST_ABSENT, 1), 1,
			rsp_of(0, 0, STAT_OK, 2, 1)});
		rows.push_back('{route_req(MODE_ROUTE_DF, 32'd1, 32'd100), 0, none});
		rows.push_back('{iface_req(MODE_ATTACH, 4'd5), 1, rsp_of(0, 0, STAT_OK, 2, 2)});
		rows.push_back('{route_req(MODE_ROUTE_DF, 32'd1, 32'd100), 0, none});
		rows.push_back('{route_req(MODE_ROUTE_DF, 32'd1, 32'hFFFF_FFFE), 0, none});
		rows.push_back('{iface_req(MODE_DETACH, 4'd5), 1, rsp_of(0, 0, STAT_OK, 2, 1)});
		rows.push_back('{route_req(MODE_ROUTE_DF, 32'd1, 32'd100), 0, none});
		rows.push_back('{iface_req(MODE_DETACH, 4'd5), 1, rsp_of(0, 0, STAT_OK, 2, 1)});
		rows.push_back('{add_req(7, 7, 7, 7, 0, 0, 4'd1, IFST_UP, 1), 1,
			rsp_of(0, 0, STAT_NOTFOUND, 2, 1)});
		rows[$].r.mode = MODE_DELETE;
		rows.push_back('{add_req(0, '1, 0, 10, 0, 0, 4'd9, IFST_UP, 1), 1,
			rsp_of(0, 0, STAT_OK, 1, 0)});
		rows[$].r.mode = MODE_DELETE;
		rows.push_back('{route_req(MODE_ROUTE_HI, 32'd5, 32'd5), 1, rsp_of(0, 0, STAT_OK, 1, 0)});
		rows.push_back('{blank_req(3'd6), 1, rsp_of(0, 0, STAT_OK, 1, 0)});
		rows.push_back('{blank_req(3'd7), 1, rsp_of(0, 0, STAT_OK, 1, 0)});
		rows.push_back('{add_req('1, '1, '1, '1, 1, 1, 4'd15, 2'd1, 0), 1,
			rsp_of(0, 0, STAT_OK, 2, 0)});
		// Detaching a rule that is attached but down still counts down, floored at zero.
		rows.push_back('{iface_req(MODE_DETACH, 4'd15), 1, rsp_of(0, 0, STAT_OK, 2, 0)});
		rows.push_back('{iface_req(MODE_ATTACH, 4'd15), 1, rsp_of(0, 0, STAT_OK, 2, 1)});
		rows.push_back('{route_req(MODE_ROUTE_HI, '1, 32'hFFFF_FFFE), 0, none});

		foreach (rows[i])
			send_request(rows[i].r, rows[i].typed, rows[i].e);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 300)
				hold_rsp = 1'b1;
			if (i >= QUIET_FROM)
				quiet = 1'b1;
			send_request(random_request((i % 400) < 120), 1'b0, none);
		end
		req_ch.valid <= 1'b0;

		waited = 0;
		while (expected_rsp_q.size() != 0 && waited < WATCHDOG_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * N + 10) @(posedge clk);

		$display("sent %0d requests: %0d route hits, %0d table-full adds, %0d unknown deletes",
			n_sent, n_hits, n_full, n_notfound);
		$display("%0d mismatches, %0d stray results, %0d results missing",
			mismatches, unexpected, expected_rsp_q.size());
		if (mismatches == 0 && unexpected == 0 && expected_rsp_q.size() == 0)
			$display("tb_source_route_range_table: done, clean");
		else
			$display("tb_source_route_range_table: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
rtl/srrt_pkg.sv
rtl/srrt_chan_if.sv
rtl/srrt_ram.sv
rtl/source_route_range_table.sv
bench/tb_source_route_range_table.sv
